// ----- rtl/core/tfmr_pkg.sv -----
package tfmr_pkg;
  localparam int unsigned FrameBitsDef = 8;
  localparam int unsigned MessageBytesDef = 16;
  localparam int unsigned FrameDepthDef = 128;
  localparam int unsigned MaxBlockFramesDef = 8;

  localparam logic [15:0] RatioReset = 16'd1280;
  localparam logic [7:0] StartNeededReset = 8'd4;
  localparam logic [7:0] TotalFramesReset = 8'd81;

  localparam logic [1:0] RegStartPattern = 2'd0;
  localparam logic [1:0] RegBlockRatio = 2'd1;
  localparam logic [1:0] RegStartNeeded = 2'd2;
  localparam logic [1:0] RegTotalFrames = 2'd3;

  typedef struct packed {
    logic [15:0] start_pattern;
    logic [15:0] block_ratio;
    logic [7:0]  start_needed;
    logic [7:0]  total_frames;
  } cfg_t;

  // Front-to-back command: store a frame, and with done set also close the message.
  typedef struct packed {
    logic        done;
    logic [15:0] frame;
  } cmd_t;
endpackage

// ----- rtl/core/tfmr_ram.sv -----
module tfmr_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- rtl/core/tfmr_front.sv -----
module tfmr_front
  import tfmr_pkg::*;
#(
  parameter int unsigned FrameBits = FrameBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] in_bits_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);
  localparam logic [15:0] FrameMask = 16'((32'd1 << FrameBits) - 32'd1);

  logic        receiving_q;
  logic [7:0]  start_count_q;
  logic [7:0]  frame_count_q;
  logic [15:0] elapsed_q;
  logic        fire;
  logic [15:0] frame;
  logic        is_start;
  logic [15:0] el_inc;
  logic [23:0] el_q8;
  logic [8:0]  fc_inc;
  logic [8:0]  sc_inc;

  // Command slot: one entry queue toward the back end.
  logic        cmd_valid_q;
  cmd_t        cmd_q;

  assign in_ready_o  = !cmd_valid_q || cmd_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign frame       = in_bits_i & FrameMask;
  assign is_start    = frame == (cfg_i.start_pattern & FrameMask);
  assign el_inc      = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
  assign el_q8       = {el_inc, 8'd0};
  assign fc_inc      = {1'b0, frame_count_q} + 9'd1;
  assign sc_inc      = {1'b0, start_count_q} + 9'd1;
  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q   <= 1'b0;
      start_count_q <= '0;
      frame_count_q <= '0;
      elapsed_q     <= '0;
      cmd_valid_q   <= 1'b0;
      cmd_q         <= '0;
    end else begin
      if (cmd_valid_q && cmd_ready_i) begin
        cmd_valid_q <= 1'b0;
      end
      if (fire) begin
        elapsed_q <= el_inc;
        if (!receiving_q) begin
          if (is_start) begin
            if (start_count_q == 8'd0) begin
              elapsed_q <= '0;
            end
            start_count_q <= sc_inc[7:0];
            if (sc_inc >= {1'b0, cfg_i.start_needed}) begin
              receiving_q   <= 1'b1;
              start_count_q <= '0;
              frame_count_q <= '0;
            end
          end else if (start_count_q != 8'd0 && el_q8 > {8'd0, cfg_i.block_ratio}) begin
            elapsed_q     <= '0;
            start_count_q <= '0;
          end
        end else if (!(frame_count_q == 8'd0 && el_q8 < {8'd0, cfg_i.block_ratio}
                       && is_start)) begin
          cmd_valid_q <= 1'b1;
          cmd_q.frame <= frame;
          cmd_q.done  <= fc_inc >= {1'b0, cfg_i.total_frames};
          if (fc_inc >= {1'b0, cfg_i.total_frames}) begin
            receiving_q   <= 1'b0;
            frame_count_q <= '0;
          end else begin
            frame_count_q <= fc_inc[7:0];
          end
        end
      end
    end
  end
endmodule

// ----- rtl/core/tfmr_back.sv -----
module tfmr_back
  import tfmr_pkg::*;
#(
  parameter int unsigned FrameBits      = FrameBitsDef,
  parameter int unsigned MessageBytes   = MessageBytesDef,
  parameter int unsigned FrameDepth     = FrameDepthDef,
  parameter int unsigned MaxBlockFrames = MaxBlockFramesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] block_ratio_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  out_index_o,
  output logic [15:0] out_value_o,
  output logic        out_agreed_o,
  output logic        out_last_o
);
  localparam int unsigned AW = $clog2(FrameDepth);
  localparam int unsigned MW = $clog2(MaxBlockFrames + 1);
  localparam int unsigned IW = (MaxBlockFrames > 1) ? $clog2(MaxBlockFrames) : 1;
  localparam bit Nibble = (FrameBits == 4);
  localparam int unsigned NBlocks = Nibble ? 2 * MessageBytes : MessageBytes;
  localparam logic [7:0] LastBlock = 8'(NBlocks - 1);
  localparam logic [7:0] TopPair = 8'(NBlocks - 2);
  localparam logic [MW-1:0] MaxCnt = MW'(MaxBlockFrames);

  typedef enum logic [2:0] {
    StIdle, StSetup, StReadI, StWaitI, StReadJ, StWaitJ, StEmit
  } state_e;

  state_e      state_q;
  logic [10:0] wptr_q;
  logic [7:0]  blk_q;
  logic [23:0] first_q;
  logic [MW-1:0] cnt_q;
  logic [IW-1:0] i_q, j_q;
  logic [15:0] cur_q, chosen_q;
  logic [MW-1:0] hits_q, best_q;
  logic [3:0]  hi_nib_q;
  logic        hi_ag_q;
  logic        out_valid_q;
  logic [5:0]  out_index_q;
  logic [15:0] out_value_q;
  logic        out_agreed_q;
  logic        out_last_q;

  logic [23:0] prod0, prod1, first_c, end_c, rd_idx;
  logic [7:0]  blk_eff;
  logic [AW-1:0] raddr;
  logic [15:0] rdata, rval;
  logic        rd_oob_q;
  logic        we;
  logic        ag_now;
  logic [15:0] pick_now;
  logic [IW:0] i_inc, j_inc;

  // In 4-tone mode byte b is built from blocks 2*(MessageBytes-1-b) and the one after it
  assign blk_eff = Nibble ? ((TopPair - {blk_q[7:1], 1'b0}) | {7'd0, blk_q[0]}) : blk_q;

  assign cmd_ready_o = (state_q == StIdle);
  assign we = cmd_valid_i && cmd_ready_o && (wptr_q < 11'(FrameDepth));
  assign prod0   = 24'(blk_eff) * {8'd0, block_ratio_i};
  assign prod1   = prod0 + {8'd0, block_ratio_i};
  assign first_c = (prod0 + 24'd128) >> 8;
  assign end_c   = prod1 >> 8;
  assign rd_idx  = first_q + 24'((state_q == StReadJ) ? j_q : i_q);
  assign raddr   = rd_idx[AW-1:0];
  assign rval    = rd_oob_q ? 16'd0 : rdata;
  assign i_inc   = {1'b0, i_q} + 1'b1;
  assign j_inc   = {1'b0, j_q} + 1'b1;
  assign ag_now  = best_q != '0;
  assign pick_now = chosen_q;

  tfmr_ram #(.Width(16), .Depth(FrameDepth)) u_store (
    .clk_i, .we_i(we), .waddr_i(wptr_q[AW-1:0]), .wdata_i(cmd_i.frame),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wptr_q      <= '0;
      blk_q       <= '0;
      out_valid_q <= 1'b0;
      rd_oob_q    <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (cmd_valid_i) begin
            wptr_q <= wptr_q + 11'd1;
            if (cmd_i.done) begin
              wptr_q  <= '0;
              blk_q   <= '0;
              state_q <= StSetup;
            end
          end
        end
        StSetup: begin
          first_q  <= first_c;
          cnt_q    <= (end_c > first_c) ?
                      ((end_c - first_c > 24'(MaxBlockFrames)) ? MaxCnt
                       : MW'(end_c - first_c)) : '0;
          i_q      <= '0;
          best_q   <= '0;
          state_q  <= StReadI;
        end
        StReadI: begin
          rd_oob_q <= rd_idx >= 24'(FrameDepth);
          state_q  <= StWaitI;
        end
        StWaitI: begin
          cur_q <= rval;
          if (i_q == '0) begin
            chosen_q <= rval;
          end
          hits_q <= '0;
          j_q    <= '0;
          if (cnt_q == '0) begin
            state_q <= StEmit;
          end else begin
            state_q <= StReadJ;
          end
        end
        StReadJ: begin
          rd_oob_q <= rd_idx >= 24'(FrameDepth);
          state_q  <= StWaitJ;
        end
        StWaitJ: begin
          logic [MW-1:0] h;
          h = hits_q + MW'((j_q != i_q) && (rval == cur_q));
          hits_q <= h;
          if (MW'(j_inc) < cnt_q) begin
            j_q     <= j_inc[IW-1:0];
            state_q <= StReadJ;
          end else begin
            if (h > best_q) begin
              best_q   <= h;
              chosen_q <= cur_q;
            end
            if (MW'(i_inc) < cnt_q) begin
              i_q     <= i_inc[IW-1:0];
              state_q <= StReadI;
            end else begin
              state_q <= StEmit;
            end
          end
        end
        StEmit: begin
          if (Nibble && !blk_q[0]) begin
            hi_nib_q <= pick_now[3:0];
            hi_ag_q  <= ag_now;
            blk_q    <= blk_q + 8'd1;
            state_q  <= StSetup;
          end else if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_index_q  <= Nibble ? blk_q[6:1] : blk_q[5:0];
            out_value_q  <= Nibble ? {8'd0, hi_nib_q, pick_now[3:0]} : pick_now;
            out_agreed_q <= Nibble ? (hi_ag_q & ag_now) : ag_now;
            out_last_q   <= (blk_q == LastBlock);
            if (blk_q == LastBlock) begin
              state_q <= StIdle;
            end else begin
              blk_q   <= blk_q + 8'd1;
              state_q <= StSetup;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_index_o  = out_index_q;
  assign out_value_o  = out_value_q;
  assign out_agreed_o = out_agreed_q;
  assign out_last_o   = out_last_q;
endmodule

// ----- rtl/core/tone_frame_message_receiver_top.sv -----
// Tone frame message receiver.
// s_axis carries one frame of tone activity bits per transaction
// (tdata[15:0] active_bits). Start frames are counted while idle; once
// enough arrive the next total_frames frames are captured into a frame store.
// The transaction that stores the final frame closes the message: the back end
// then picks the most repeated frame of each time block and sends one m_axis
// transaction per message word in byte_index order (tdata: [5:0] byte_index,
// [21:6] value, [22] agreed; tlast = last word).
// Front end: one frame per cycle into a one-entry command slot while it is free.
// Back end: per time block, reads each of n frames examined (n <= the maximum
// per block) and for each all n again, one read of the single store port per
// step; an empty block takes one read. A message takes one pass per block
// after its final frame: MESSAGE_BYTES blocks, twice as many in 4-tone mode.
// During that pass s_axis_tready drops once the slot fills. A stalled m_axis
// holds the word in the output register and the back end. Reset clears all
// control state and restores register defaults; the frame store is not cleared.
// The user writes APB port registers only while idle; the block does not check.
module tone_frame_message_receiver_top
  import tfmr_pkg::*;
#(
  parameter int unsigned FrameBits      = FrameBitsDef,
  parameter int unsigned MessageBytes   = MessageBytesDef,
  parameter int unsigned FrameDepth     = FrameDepthDef,
  parameter int unsigned MaxBlockFrames = MaxBlockFramesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] active_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [5:0] byte_index, [21:6] value, [22] agreed
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  cfg_t        cfg_q;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;
  logic [5:0]  o_idx;
  logic [15:0] o_val;
  logic        o_ag;
  logic [1:0]  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{start_pattern: 16'd0, block_ratio: RatioReset,
                 start_needed: StartNeededReset, total_frames: TotalFramesReset};
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        RegStartPattern: cfg_q.start_pattern <= pwdata[15:0];
        RegBlockRatio:   cfg_q.block_ratio   <= pwdata[15:0];
        RegStartNeeded:  cfg_q.start_needed  <= pwdata[7:0];
        RegTotalFrames:  cfg_q.total_frames  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegStartPattern: prdata = {16'd0, cfg_q.start_pattern};
      RegBlockRatio:   prdata = {16'd0, cfg_q.block_ratio};
      RegStartNeeded:  prdata = {24'd0, cfg_q.start_needed};
      RegTotalFrames:  prdata = {24'd0, cfg_q.total_frames};
      default:         prdata = '0;
    endcase
  end

  tfmr_front #(.FrameBits(FrameBits)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_bits_i(s_axis_tdata),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  tfmr_back #(
    .FrameBits(FrameBits), .MessageBytes(MessageBytes),
    .FrameDepth(FrameDepth), .MaxBlockFrames(MaxBlockFrames)
  ) u_back (
    .clk_i, .rst_ni, .block_ratio_i(cfg_q.block_ratio),
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_index_o(o_idx), .out_value_o(o_val), .out_agreed_o(o_ag),
    .out_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, o_ag, o_val, o_idx};

`ifndef SYNTHESIS
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> o_idx == 6'(MessageBytes - 1))
    else $error("tlast on wrong word");
  a_cmd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
    else $error("command dropped");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
`endif
endmodule
